// ===== rtl/sts_pkg.sv =====
// Shared types, constants and shaping ROM contents for the stereo tanh saturator.
`timescale 1ns / 1ps
`default_nettype none
package sts_pkg;

	// Sample and table geometry
	localparam int SAMPLE_W        = 24;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int TBL_N           = 1 << TABLE_ADDR_BITS;
	localparam int TBL_Q4          = TBL_N / 4;
	localparam int TBL_W           = 22;
	localparam int SIN_FB          = 32 - TABLE_ADDR_BITS;
	localparam int TANH_FB         = 23 - TABLE_ADDR_BITS;
	localparam int FRAC_W          = SIN_FB;

	// Configuration
	localparam int          AMT_W     = 13;
	localparam logic [12:0] AMT_MAX   = 13'd4096;
	localparam logic [12:0] AMT_RESET = 13'd2048;
	localparam int          PADDR_W   = 4;

	// Divider geometry
	localparam int DIV_NUM_W = 41;
	localparam int DIV_DEN_W = 21;

	// Elaboration constants for ROM generation
	localparam longint ONE_Q30 = 64'sd1 << 30;
	localparam longint PI_Q30  = 64'sd3373259426;

	typedef enum logic [1:0] {
		REG_DRIVE,
		REG_CHARACTER,
		REG_SATURATION,
		REG_PRESENCE
	} sts_reg_idx_t;

	typedef struct packed {
		logic [AMT_W-1:0] drive;
		logic [AMT_W-1:0] character;
		logic [AMT_W-1:0] saturation;
		logic [AMT_W-1:0] presence;
	} sts_cfg_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} sts_div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} sts_div_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TS_LOOK,
		ST_TS_MUL,
		ST_TS_FIN,
		ST_G,
		ST_X1,
		ST_PH,
		ST_SIN0,
		ST_SIN1,
		ST_SIN2,
		ST_CH,
		ST_CH2,
		ST_CH3,
		ST_CH4,
		ST_TA,
		ST_TA2,
		ST_TA3,
		ST_TA4,
		ST_TA5,
		ST_DIV,
		ST_PR,
		ST_PR2,
		ST_PR3,
		ST_PR4,
		ST_OUT
	} sts_state_t;

	typedef logic [TBL_N-1:0][TBL_W-1:0] sin_rom_t;
	typedef logic [TBL_N:0][TBL_W-1:0]   tanh_rom_t;

	// Unsigned long division by shift and subtract, elaboration only
	function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Divide, round to nearest, ties away from zero
	function automatic longint rdiv64(longint n, longint d);
		longint unsigned m;
		longint unsigned q;
		m = (n < 0) ? 64'(-n) : 64'(n);
		q = udiv64(m + (64'(d) >> 1), 64'(d));
		return (n < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint quarter_sin(longint m);
		longint th;
		longint th2;
		longint term;
		longint sum;
		th   = rdiv64(PI_Q30 * 2 * m, longint'(TBL_N));
		th2  = rdiv64(th * th, ONE_Q30);
		term = th;
		sum  = th;
		for (int n = 1; n <= 9; n++) begin
			term = -rdiv64(term * th2, longint'((2 * n) * (2 * n + 1)) * ONE_Q30);
			sum  = sum + term;
		end
		return rdiv64(sum, 64'sd1024);
	endfunction

	function automatic longint tanh_entry(longint k);
		longint u;
		longint term;
		longint t;
		u    = k << (29 - TABLE_ADDR_BITS);
		term = ONE_Q30;
		t    = ONE_Q30;
		for (int n = 1; n <= 14; n++) begin
			term = -rdiv64(term * u, longint'(n) * ONE_Q30);
			t    = t + term;
		end
		for (int n = 0; n < 5; n++) begin
			t = rdiv64(t * t, ONE_Q30);
		end
		return rdiv64((ONE_Q30 - t) << 20, ONE_Q30 + t);
	endfunction

	function automatic sin_rom_t build_sin();
		sin_rom_t r;
		longint   v;
		int       q;
		int       rr;
		for (int k = 0; k < TBL_N; k++) begin
			q  = k / TBL_Q4;
			rr = k % TBL_Q4;
			v  = ((q & 1) != 0) ? quarter_sin(longint'(TBL_Q4 - rr)) : quarter_sin(longint'(rr));
			if ((q & 2) != 0) begin
				v = -v;
			end
			r[k] = TBL_W'(v);
		end
		return r;
	endfunction

	function automatic tanh_rom_t build_tanh();
		tanh_rom_t r;
		for (int k = 0; k <= TBL_N; k++) begin
			r[k] = TBL_W'(tanh_entry(longint'(k)));
		end
		return r;
	endfunction

	localparam sin_rom_t  SIN_ROM  = build_sin();
	localparam tanh_rom_t TANH_ROM = build_tanh();

endpackage
`default_nettype wire

// ===== rtl/sts_if.sv =====
// Sample pair and shaped result channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface sts_in_if import sts_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_in;
	logic signed [SAMPLE_W-1:0] right_in;
	logic                       block_end;

	modport source(output valid, left_in, right_in, block_end, input ready);
	modport sink(input valid, left_in, right_in, block_end, output ready);
endinterface

interface sts_out_if import sts_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;
	logic                       block_end_out;
	logic                       clipped;

	modport source(output valid, left_out, right_out, block_end_out, clipped, input ready);
	modport sink(input valid, left_out, right_out, block_end_out, clipped, output ready);
endinterface
`default_nettype wire

// ===== rtl/sts_regs.sv =====
// APB configuration registers with range clamping.
`timescale 1ns / 1ps
`default_nettype none
module sts_regs import sts_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	output sts_cfg_t                cfg
);

	logic [AMT_W-1:0] drive_q;
	logic [AMT_W-1:0] character_q;
	logic [AMT_W-1:0] saturation_q;
	logic [AMT_W-1:0] presence_q;
	sts_reg_idx_t     idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = sts_reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q      <= AMT_RESET;
			character_q  <= AMT_RESET;
			saturation_q <= AMT_RESET;
			presence_q   <= AMT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_DRIVE:      drive_q      <= pwdata[AMT_W-1:0];
				REG_CHARACTER:  character_q  <= pwdata[AMT_W-1:0];
				REG_SATURATION: saturation_q <= pwdata[AMT_W-1:0];
				REG_PRESENCE:   presence_q   <= pwdata[AMT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the stored value
	always_comb begin
		unique case (idx)
			REG_DRIVE:      prdata = 32'(drive_q);
			REG_CHARACTER:  prdata = 32'(character_q);
			REG_SATURATION: prdata = 32'(saturation_q);
			REG_PRESENCE:   prdata = 32'(presence_q);
			default:        prdata = '0;
		endcase
	end

	// Clamp each control to 1.0
	assign cfg.drive      = (drive_q > AMT_MAX) ? AMT_MAX : drive_q;
	assign cfg.character  = (character_q > AMT_MAX) ? AMT_MAX : character_q;
	assign cfg.saturation = (saturation_q > AMT_MAX) ? AMT_MAX : saturation_q;
	assign cfg.presence   = (presence_q > AMT_MAX) ? AMT_MAX : presence_q;

endmodule
`default_nettype wire

// ===== rtl/sts_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sts_div import sts_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  sts_div_req_t req,
	output sts_div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_NUM_W-1:0] acc_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   r2;
	logic                 qbit;
	logic [DIV_DEN_W-1:0] rem_nxt;

	// Shift in the next dividend bit and try a subtract
	assign r2      = {rem_q, acc_q[DIV_NUM_W-1]};
	assign qbit    = r2 >= {1'b0, den_q};
	assign rem_nxt = qbit ? DIV_DEN_W'(r2 - {1'b0, den_q}) : DIV_DEN_W'(r2);

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits replace dividend bits in the same shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			acc_q <= {acc_q[DIV_NUM_W-2:0], qbit};
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = acc_q;

endmodule
`default_nettype wire

// ===== rtl/sts_engine.sv =====
// Sequencer and shared-multiplier datapath that shapes both channels.
`timescale 1ns / 1ps
`default_nettype none
module sts_engine import sts_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  sts_cfg_t     cfg,
	sts_in_if.sink       audio,
	sts_out_if.source    shaped,
	output sts_div_req_t div_req,
	input  sts_div_rsp_t div_rsp
);

	localparam int          X1_SH   = SAMPLE_W - 9;
	localparam int          CH_SH   = 13;
	localparam logic [63:0] CH_HALF = 64'd20480;
	localparam int          PR_SH   = 12;
	localparam logic [63:0] PR_HALF = 64'd10240;
	localparam int          TA_SH   = 13;
	localparam int          RC_SH   = 34;
	localparam logic signed [33:0] INV2PI = 34'sd683565276;
	localparam logic signed [33:0] RECIP5 = 34'sh0CCCCCCCD;
	localparam logic [25:0] TANH_LIM = 26'd1 << 23;
	localparam logic [20:0] TANH_ONE = 21'd1 << 20;
	localparam logic signed [27:0] OUT_HI = 28'sd8388607;
	localparam logic signed [27:0] OUT_LO = -28'sd8388608;

	// Round to nearest by a power of two, ties away from zero
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] n,
			input int unsigned sh);
		logic [63:0] m;
		logic [63:0] q;
		m = n[63] ? 64'(-n) : 64'(n);
		q = (m + (64'd1 << (sh - 1))) >> sh;
		return n[63] ? -$signed(q) : $signed(q);
	endfunction

	sts_state_t state_q;
	sts_state_t state_d;

	logic                       ch_q;
	logic signed [SAMPLE_W-1:0] xl_q;
	logic signed [SAMPLE_W-1:0] xr_q;
	logic                       be_q;
	logic signed [63:0]         prod_q;
	logic signed [24:0]         x1_q;
	logic signed [TBL_W-1:0]    sin_q;
	logic signed [TBL_W-1:0]    base_q;
	logic signed [TBL_W:0]      diff_q;
	logic [FRAC_W-1:0]          frac_q;
	logic                       neg_q;
	logic                       sat_q;
	logic                       sneg_q;
	logic [31:0]                v_q;
	logic signed [25:0]         arg_q;
	logic [DIV_DEN_W-1:0]       ts_q;
	logic signed [22:0]         y_q;
	logic signed [SAMPLE_W-1:0] prev_q [2];
	logic signed [SAMPLE_W-1:0] res_l_q;
	logic signed [SAMPLE_W-1:0] res_r_q;
	logic                       clip_q;
	logic                       oval_q;
	logic signed [SAMPLE_W-1:0] out_l_q;
	logic signed [SAMPLE_W-1:0] out_r_q;
	logic                       out_be_q;
	logic                       out_clip_q;

	logic signed [33:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [67:0] full;
	logic               load;
	logic               accept;

	logic [15:0]                g;
	logic [13:0]                s13;
	logic [15:0]                c9;
	logic [14:0]                p3;
	logic signed [SAMPLE_W-1:0] x_sel;
	logic signed [SAMPLE_W-1:0] prev_sel;
	logic signed [24:0]         dpr;
	logic [31:0]                ph;
	logic [TABLE_ADDR_BITS-1:0] si;
	logic [TABLE_ADDR_BITS-1:0] sj;
	logic [25:0]                am;
	logic [TABLE_ADDR_BITS:0]   ti;
	logic [TABLE_ADDR_BITS:0]   ti1;
	logic [63:0]                absp;
	logic [29:0]                q5;
	logic [20:0]                tanh_mag;
	logic signed [27:0]         z;

	// Derived coefficients
	assign g   = 16'd4096 + {cfg.drive, 3'b0} + {2'b0, cfg.drive, 1'b0};
	assign s13 = 14'd4096 + {1'b0, cfg.saturation};
	assign c9  = {cfg.character, 3'b0} + {3'b0, cfg.character};
	assign p3  = {1'b0, cfg.presence, 1'b0} + {2'b0, cfg.presence};

	assign x_sel    = ch_q ? xr_q : xl_q;
	assign prev_sel = prev_q[ch_q];
	assign dpr      = 25'(y_q) - 25'(prev_sel);

	// Sine phase and table addresses
	assign ph = prod_q[51:20];
	assign si = ph[31 -: TABLE_ADDR_BITS];
	assign sj = si + 1'b1;

	// Tanh magnitude and table addresses
	assign am  = arg_q[25] ? 26'(-arg_q) : 26'(arg_q);
	assign ti  = {1'b0, am[22 -: TABLE_ADDR_BITS]};
	assign ti1 = ti + 1'b1;

	assign absp     = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
	assign q5       = prod_q[63:RC_SH];
	assign tanh_mag = sat_q ? TANH_ONE :
		21'(64'(base_q) + rnd_shr(prod_q, TANH_FB));
	assign z = 28'(y_q) + (sneg_q ? -28'(q5) : 28'(q5));

	assign full = mul_a * mul_b;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (audio.valid) state_d = ST_TS_LOOK;
			ST_TS_LOOK: state_d = ST_TS_MUL;
			ST_TS_MUL:  state_d = ST_TS_FIN;
			ST_TS_FIN:  state_d = ST_G;
			ST_G:       state_d = ST_X1;
			ST_X1:      state_d = ST_PH;
			ST_PH:      state_d = ST_SIN0;
			ST_SIN0:    state_d = ST_SIN1;
			ST_SIN1:    state_d = ST_SIN2;
			ST_SIN2:    state_d = ST_CH;
			ST_CH:      state_d = ST_CH2;
			ST_CH2:     state_d = ST_CH3;
			ST_CH3:     state_d = ST_CH4;
			ST_CH4:     state_d = ST_TA;
			ST_TA:      state_d = ST_TA2;
			ST_TA2:     state_d = ST_TA3;
			ST_TA3:     state_d = ST_TA4;
			ST_TA4:     state_d = ST_TA5;
			ST_TA5:     state_d = ST_DIV;
			ST_DIV:     if (div_rsp.done) state_d = ST_PR;
			ST_PR:      state_d = ST_PR2;
			ST_PR2:     state_d = ST_PR3;
			ST_PR3:     state_d = ST_PR4;
			ST_PR4:     state_d = ch_q ? ST_OUT : ST_G;
			ST_OUT:     if (!oval_q || shaped.ready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Multiplier operands and strobes
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_G: begin
				mul_a = 34'(x_sel);
				mul_b = 34'(g);
			end
			ST_PH: begin
				mul_a = 34'(x1_q);
				mul_b = INV2PI;
			end
			ST_SIN1, ST_TA4, ST_TS_MUL: begin
				mul_a = 34'(diff_q);
				mul_b = 34'(frac_q);
			end
			ST_CH: begin
				mul_a = 34'(sin_q);
				mul_b = 34'(c9);
			end
			ST_CH3, ST_PR3: begin
				mul_a = 34'(v_q);
				mul_b = RECIP5;
			end
			ST_TA: begin
				mul_a = 34'(x1_q);
				mul_b = 34'(s13);
			end
			ST_PR: begin
				mul_a = 34'(dpr);
				mul_b = 34'(p3);
			end
			default: ;
		endcase
		audio.ready   = (state_q == ST_IDLE);
		load          = (state_q == ST_OUT) && (!oval_q || shaped.ready);
		div_req.start = (state_q == ST_TA5);
		div_req.num   = {tanh_mag, 20'b0} + DIV_NUM_W'(ts_q >> 1);
		div_req.den   = ts_q;
	end

	assign accept = audio.valid && audio.ready;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ch_q      <= 1'b0;
			oval_q    <= 1'b0;
			prev_q[0] <= '0;
			prev_q[1] <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				ch_q <= 1'b0;
			end else if (state_q == ST_PR4) begin
				ch_q <= ~ch_q;
			end
			if (state_q == ST_PR4) begin
				prev_q[ch_q] <= (z > OUT_HI) ? SAMPLE_W'(OUT_HI) :
					(z < OUT_LO) ? SAMPLE_W'(OUT_LO) : SAMPLE_W'(z);
			end
			if (load) begin
				oval_q <= 1'b1;
			end else if (shaped.ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	// Datapath registers, advanced per step
	always_ff @(posedge clk) begin
		prod_q <= full[63:0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					xl_q   <= audio.left_in;
					xr_q   <= audio.right_in;
					be_q   <= audio.block_end;
					arg_q  <= 26'({s13, 7'b0});
					clip_q <= 1'b0;
				end
			end
			ST_TS_LOOK, ST_TA3: begin
				base_q <= $signed(TANH_ROM[ti]);
				diff_q <= (TBL_W + 1)'($signed(TANH_ROM[ti1])) -
					(TBL_W + 1)'($signed(TANH_ROM[ti]));
				frac_q <= FRAC_W'(am[TANH_FB-1:0]);
				neg_q  <= arg_q[25];
				sat_q  <= am >= TANH_LIM;
			end
			ST_TS_FIN: ts_q <= tanh_mag;
			ST_X1:     x1_q <= 25'(rnd_shr(prod_q, X1_SH));
			ST_SIN0: begin
				base_q <= $signed(SIN_ROM[si]);
				diff_q <= (TBL_W + 1)'($signed(SIN_ROM[sj])) -
					(TBL_W + 1)'($signed(SIN_ROM[si]));
				frac_q <= ph[SIN_FB-1:0];
				sat_q  <= 1'b0;
			end
			ST_SIN2: sin_q <= TBL_W'(64'(base_q) + rnd_shr(prod_q, SIN_FB));
			ST_CH2: begin
				v_q    <= 32'((absp + CH_HALF) >> CH_SH);
				sneg_q <= prod_q[63];
			end
			ST_CH4: x1_q  <= x1_q + (sneg_q ? -25'(q5) : 25'(q5));
			ST_TA2: arg_q <= 26'(rnd_shr(prod_q, TA_SH));
			ST_DIV: begin
				if (div_rsp.done) begin
					y_q <= neg_q ? -23'(div_rsp.quo) : 23'(div_rsp.quo);
				end
			end
			ST_PR2: begin
				v_q    <= 32'((absp + PR_HALF) >> PR_SH);
				sneg_q <= prod_q[63];
			end
			ST_PR4: begin
				if (ch_q) begin
					res_r_q <= (z > OUT_HI) ? SAMPLE_W'(OUT_HI) :
						(z < OUT_LO) ? SAMPLE_W'(OUT_LO) : SAMPLE_W'(z);
				end else begin
					res_l_q <= (z > OUT_HI) ? SAMPLE_W'(OUT_HI) :
						(z < OUT_LO) ? SAMPLE_W'(OUT_LO) : SAMPLE_W'(z);
				end
				clip_q <= clip_q || (z > OUT_HI) || (z < OUT_LO);
			end
			default: ;
		endcase
		if (load) begin
			out_l_q    <= res_l_q;
			out_r_q    <= res_r_q;
			out_be_q   <= be_q;
			out_clip_q <= clip_q;
		end
	end

	assign shaped.valid         = oval_q;
	assign shaped.left_out      = out_l_q;
	assign shaped.right_out     = out_r_q;
	assign shaped.block_end_out = out_be_q;
	assign shaped.clipped       = out_clip_q;

endmodule
`default_nettype wire

// ===== rtl/stereo_tanh_saturator_core.sv =====
// Top level of the stereo tanh saturator.
`timescale 1ns / 1ps
`default_nettype none
// Stereo tanh soft-clip waveshaper. Each accepted sample pair is shaped one
// channel after the other by a small sequencer around one shared multiplier
// and a bit-serial divider: drive gain, sine shaping, normalized tanh, then
// presence emphasis against that channel's previous output, saturated to
// Q3.20 with a clip flag. The 41-step serial divider runs once per channel;
// the input is not ready while a pair is in work. The finished pair sits in
// an output register, so the next pair can be taken while it waits.
// Registers sit on an APB port at byte addresses 0, 4, 8 and 12 and should be
// written only while the block is idle.
module stereo_tanh_saturator_core import sts_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	sts_in_if.sink                  audio,
	sts_out_if.source               shaped,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	sts_cfg_t     cfg;
	sts_div_req_t div_req;
	sts_div_rsp_t div_rsp;

	sts_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	sts_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.audio   (audio),
		.shaped  (shaped),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

endmodule
`default_nettype wire

// ===== rtl/sts_checker.sv =====
// Port-level checks for the stereo tanh saturator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sts_checker import sts_pkg::*; (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic signed [SAMPLE_W-1:0] left_out,
	input wire logic signed [SAMPLE_W-1:0] right_out
);

	// A taken pair blocks the input on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input still ready after a transaction");

	// No result appears right after a pair is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result raised one cycle after input transaction");

	// The engine is idle again when a result is presented
	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result presented while engine busy");

	// Hold a stalled result
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
		else $error("stalled result changed or dropped");

endmodule

bind stereo_tanh_saturator_core sts_checker u_sts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (audio.valid),
	.in_ready  (audio.ready),
	.out_valid (shaped.valid),
	.out_ready (shaped.ready),
	.left_out  (shaped.left_out),
	.right_out (shaped.right_out)
);
`default_nettype wire
